### design/scfp_pkg.sv
`timescale 1ns / 1ps

package scfp_pkg;

  // payload sizing
  localparam int PAYLOAD_CAPACITY = 32;
  localparam int PAY_IDX_W        = $clog2(PAYLOAD_CAPACITY + 1);
  localparam int SETTINGS_LEN     = 13;
  localparam int SET_IDX_W        = $clog2(SETTINGS_LEN);

  // frame constants
  localparam logic [7:0] SYNC_WORD [4] = '{8'h4F, 8'h52, 8'h42, 8'h59};
  localparam logic [7:0] FACTORY [SETTINGS_LEN] = '{
    8'd1, 8'd0, 8'd1, 8'd0, 8'd120, 8'd0, 8'd60, 8'd0, 8'd30, 8'd0, 8'd10, 8'd0, 8'd0
  };
  localparam logic [7:0] RESP_FLAG  = 8'h80;
  localparam logic [7:0] ERR_HDR    = 8'hFF;
  localparam logic [4:0] ERR_LEN    = 5'd1;
  localparam logic [4:0] GET_LEN    = 5'd16;
  localparam logic [7:0] SET_LEN    = 8'd16;
  localparam logic [7:0] SET_VER    = 8'h01;
  localparam logic [4:0] HDR_BYTES  = 5'd6;

  // command codes
  localparam logic [7:0] CMD_GET     = 8'h10;
  localparam logic [7:0] CMD_SET     = 8'h11;
  localparam logic [7:0] CMD_SAVE    = 8'h12;
  localparam logic [7:0] CMD_RESTORE = 8'h13;

  // error codes
  localparam logic [7:0] ERR_LENGTH  = 8'h01;
  localparam logic [7:0] ERR_SUM     = 8'h02;
  localparam logic [7:0] ERR_VERSION = 8'h03;
  localparam logic [7:0] ERR_COMMAND = 8'h04;

  typedef enum logic [3:0] {
    PH_SYNC0,
    PH_SYNC1,
    PH_SYNC2,
    PH_SYNC3,
    PH_CMD,
    PH_LEN,
    PH_PAY,
    PH_CHK,
    PH_TX
  } phase_t;

  // controller to datapath
  typedef struct packed {
    logic [1:0] sync_sel;
    logic       ld_cmd;
    logic       ld_len;
    logic       ld_pay;
    logic       run_chk;
    logic       err_len;
    logic       tx_step;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic sync_ok;
    logic len_over;
    logic len_zero;
    logic pay_last;
    logic out_free;
    logic tx_last;
  } sts_t;

endpackage

### design/scfp_ctrl.sv
`timescale 1ns / 1ps

module scfp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  scfp_pkg::sts_t sts,
  output scfp_pkg::ctl_t ctl
);

  scfp_pkg::phase_t state_r, state_nxt;
  logic acc;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scfp_pkg::PH_SYNC0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r != scfp_pkg::PH_TX);
  assign acc       = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      scfp_pkg::PH_SYNC0, scfp_pkg::PH_SYNC1, scfp_pkg::PH_SYNC2,
      scfp_pkg::PH_SYNC3: begin
        ctl.sync_sel = state_r[1:0];
        if (acc) begin
          if (!sts.sync_ok) begin
            state_nxt = scfp_pkg::PH_SYNC0;
          end else begin
            case (state_r)
              scfp_pkg::PH_SYNC0: state_nxt = scfp_pkg::PH_SYNC1;
              scfp_pkg::PH_SYNC1: state_nxt = scfp_pkg::PH_SYNC2;
              scfp_pkg::PH_SYNC2: state_nxt = scfp_pkg::PH_SYNC3;
              default:            state_nxt = scfp_pkg::PH_CMD;
            endcase
          end
        end
      end
      scfp_pkg::PH_CMD: begin
        ctl.ld_cmd = acc;
        if (acc) state_nxt = scfp_pkg::PH_LEN;
      end
      scfp_pkg::PH_LEN: begin
        ctl.ld_len = acc;
        if (acc) begin
          if (sts.len_over) begin
            ctl.err_len = 1'b1;
            state_nxt   = scfp_pkg::PH_TX;
          end else if (sts.len_zero) begin
            state_nxt = scfp_pkg::PH_CHK;
          end else begin
            state_nxt = scfp_pkg::PH_PAY;
          end
        end
      end
      scfp_pkg::PH_PAY: begin
        ctl.ld_pay = acc;
        if (acc && sts.pay_last) state_nxt = scfp_pkg::PH_CHK;
      end
      scfp_pkg::PH_CHK: begin
        ctl.run_chk = acc;
        if (acc) state_nxt = scfp_pkg::PH_TX;
      end
      scfp_pkg::PH_TX: begin
        ctl.tx_step = sts.out_free;
        if (sts.out_free && sts.tx_last) state_nxt = scfp_pkg::PH_SYNC0;
      end
      default: begin
        state_nxt = scfp_pkg::PH_SYNC0;
      end
    endcase
  end

endmodule

### design/scfp_dp.sv
`timescale 1ns / 1ps

module scfp_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_tdata,
  input  scfp_pkg::ctl_t ctl,
  output scfp_pkg::sts_t sts,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic           out_tuser
);

  // receive side
  logic [7:0]                     cmd_r;
  logic [7:0]                     len_r;
  logic [scfp_pkg::PAY_IDX_W-1:0] idx_r;
  logic [7:0]                     rx_sum_r;
  logic [7:0]                     stage_r [scfp_pkg::SETTINGS_LEN];
  logic [7:0]                     settings_r [scfp_pkg::SETTINGS_LEN];

  // transmit side
  logic [7:0] tx_hdr_r;
  logic [4:0] tx_len_r;
  logic [7:0] tx_code_r;
  logic       tx_get_r;
  logic       tx_save_r;
  logic [4:0] tx_ptr_r;
  logic [7:0] tx_sum_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_user_r;

  logic [7:0] chk_sum;
  logic       is_err;
  logic [7:0] err_code;
  logic       do_set;
  logic       do_restore;
  logic [4:0] pay_pos;
  logic [7:0] tx_byte;
  logic       tx_last;

  // status
  assign chk_sum      = rx_sum_r;
  assign sts.sync_ok  = (in_tdata == scfp_pkg::SYNC_WORD[ctl.sync_sel]);
  assign sts.len_over = ({1'b0, in_tdata} > 9'(scfp_pkg::PAYLOAD_CAPACITY));
  assign sts.len_zero = (in_tdata == 8'd0);
  assign sts.pay_last = ((9'(idx_r) + 9'd1) == {1'b0, len_r});
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.tx_last  = tx_last;

  // frame verdict on the checksum beat
  always_comb begin
    is_err     = 1'b1;
    err_code   = scfp_pkg::ERR_COMMAND;
    do_set     = 1'b0;
    do_restore = 1'b0;
    if (chk_sum != in_tdata) begin
      err_code = scfp_pkg::ERR_SUM;
    end else if (cmd_r == scfp_pkg::CMD_GET && len_r == 8'd0) begin
      is_err = 1'b0;
    end else if (cmd_r == scfp_pkg::CMD_SET && len_r == scfp_pkg::SET_LEN) begin
      if (stage_r[0] != scfp_pkg::SET_VER) begin
        err_code = scfp_pkg::ERR_VERSION;
      end else begin
        is_err = 1'b0;
        do_set = 1'b1;
      end
    end else if (cmd_r == scfp_pkg::CMD_SAVE && len_r == 8'd0) begin
      is_err = 1'b0;
    end else if (cmd_r == scfp_pkg::CMD_RESTORE && len_r == 8'd0) begin
      is_err     = 1'b0;
      do_restore = 1'b1;
    end
  end

  // receive registers and payload staging
  always_ff @(posedge clk) begin
    if (ctl.ld_cmd) begin
      cmd_r    <= in_tdata;
      rx_sum_r <= in_tdata;
    end
    if (ctl.ld_len) begin
      len_r    <= in_tdata;
      rx_sum_r <= rx_sum_r + in_tdata;
      idx_r    <= '0;
    end
    if (ctl.ld_pay) begin
      rx_sum_r <= rx_sum_r + in_tdata;
      idx_r    <= idx_r + 1'b1;
      if (idx_r < scfp_pkg::PAY_IDX_W'(scfp_pkg::SETTINGS_LEN)) begin
        stage_r[scfp_pkg::SET_IDX_W'(idx_r)] <= in_tdata;
      end
    end
  end

  // settings store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scfp_pkg::SETTINGS_LEN; i++) settings_r[i] <= scfp_pkg::FACTORY[i];
    end else if (ctl.run_chk && do_set) begin
      for (int i = 0; i < scfp_pkg::SETTINGS_LEN; i++) settings_r[i] <= stage_r[i];
    end else if (ctl.run_chk && do_restore) begin
      for (int i = 0; i < scfp_pkg::SETTINGS_LEN; i++) settings_r[i] <= scfp_pkg::FACTORY[i];
    end
  end

  // byte at the transmit pointer
  assign pay_pos = tx_ptr_r - scfp_pkg::HDR_BYTES;
  assign tx_last = (tx_ptr_r == scfp_pkg::HDR_BYTES + tx_len_r);

  always_comb begin
    if (tx_ptr_r < 5'd4) begin
      tx_byte = scfp_pkg::SYNC_WORD[tx_ptr_r[1:0]];
    end else if (tx_ptr_r == 5'd4) begin
      tx_byte = tx_hdr_r;
    end else if (tx_ptr_r == 5'd5) begin
      tx_byte = {3'b000, tx_len_r};
    end else if (tx_last) begin
      tx_byte = tx_sum_r;
    end else if (!tx_get_r) begin
      tx_byte = tx_code_r;
    end else if (pay_pos < 5'(scfp_pkg::SETTINGS_LEN)) begin
      tx_byte = settings_r[scfp_pkg::SET_IDX_W'(pay_pos)];
    end else begin
      tx_byte = 8'd0;
    end
  end

  // transmit sequencer
  always_ff @(posedge clk) begin
    if (ctl.err_len) begin
      tx_hdr_r  <= scfp_pkg::ERR_HDR;
      tx_len_r  <= scfp_pkg::ERR_LEN;
      tx_code_r <= scfp_pkg::ERR_LENGTH;
      tx_get_r  <= 1'b0;
      tx_save_r <= 1'b0;
      tx_ptr_r  <= '0;
      tx_sum_r  <= '0;
    end else if (ctl.run_chk) begin
      tx_code_r <= err_code;
      tx_ptr_r  <= '0;
      tx_sum_r  <= '0;
      if (is_err) begin
        tx_hdr_r  <= scfp_pkg::ERR_HDR;
        tx_len_r  <= scfp_pkg::ERR_LEN;
        tx_get_r  <= 1'b0;
        tx_save_r <= 1'b0;
      end else begin
        tx_hdr_r  <= cmd_r | scfp_pkg::RESP_FLAG;
        tx_len_r  <= (cmd_r == scfp_pkg::CMD_GET) ? scfp_pkg::GET_LEN : 5'd0;
        tx_get_r  <= (cmd_r == scfp_pkg::CMD_GET);
        tx_save_r <= (cmd_r == scfp_pkg::CMD_SAVE);
      end
    end else if (ctl.tx_step) begin
      tx_ptr_r <= tx_ptr_r + 5'd1;
      if (tx_ptr_r >= 5'd4 && !tx_last) tx_sum_r <= tx_sum_r + tx_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.tx_step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tx_step) begin
      out_data_r <= tx_byte;
      out_last_r <= tx_last;
      out_user_r <= tx_last && tx_save_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

### design/serial_command_frame_parser_top.sv
`timescale 1ns / 1ps

// Serial command frame parser. Each input beat is one received byte; the block
// hunts for the four-byte sync word, reads command, length, payload and sum, and
// answers a whole frame with a response or error frame of 7 to 23 bytes, one
// byte per output beat with tlast on the sum byte and tuser marking a save
// request. Bytes are taken one per cycle while a frame is being received; the
// byte that completes a frame (or a length byte above 32) starts the reply, and
// no further byte is taken until the transmit sequencer has loaded the reply's
// last byte into the output register.
module serial_command_frame_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast,  // frame_end
  output logic       out_tuser   // [0] save_request
);

  scfp_pkg::ctl_t ctl;
  scfp_pkg::sts_t sts;

  scfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  scfp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### design/scfp_chk.sv
`timescale 1ns / 1ps

module scfp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // save flag only on a frame's last byte
  a_save_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("save request away from frame end");

  // no input taken while a reply is mid-frame
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted during reply");

  // every reply starts with the first sync byte
  a_first_sync: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tdata == scfp_pkg::SYNC_WORD[0])
    else $error("reply did not open with sync");

endmodule

bind serial_command_frame_parser_top scfp_chk u_scfp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RX_ITEMS       = 360;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 32;
  localparam int REPORT_LIMIT   = 10;
  localparam int REPLY_MAX      = 16;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_ERROR,
    ROW_DEFAULTS
  } row_kind_t;

  typedef struct packed {
    logic [7:0] rx;
    row_kind_t  kind;
    logic [7:0] code;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       save;
  } tx_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  // tag of the beat on the input side, read by the monitor
  row_kind_t  beat_kind = ROW_PREDICT;
  logic [7:0] beat_code = 8'h00;

  // parser state as predicted
  scfp_pkg::phase_t rx_phase;
  logic [7:0]       rx_cmd;
  logic [7:0]       rx_len;
  int unsigned      rx_idx;
  logic [7:0]       rx_payload [scfp_pkg::PAYLOAD_CAPACITY];
  logic [7:0]       stored_settings [scfp_pkg::SETTINGS_LEN];

  logic [7:0] reply_body [REPLY_MAX];
  tx_beat_t   reply_frame [$];
  tx_beat_t   tx_expected [$];

  int mismatches = 0;
  int tx_count = 0;
  int rx_items = 0;

  // stray byte, get after reset, oversize length, save, restore with a bad sum
  stim_row_t directed_rows [28] = '{
    '{8'h00,                  ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[0], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[1], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[2], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[3], ROW_QUIET,    8'h00},
    '{scfp_pkg::CMD_GET,      ROW_QUIET,    8'h00},
    '{8'h00,                  ROW_QUIET,    8'h00},
    '{scfp_pkg::CMD_GET,      ROW_DEFAULTS, 8'h00},
    '{scfp_pkg::SYNC_WORD[0], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[1], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[2], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[3], ROW_QUIET,    8'h00},
    '{scfp_pkg::CMD_RESTORE,  ROW_QUIET,    8'h00},
    '{8'hFF,                  ROW_ERROR,    scfp_pkg::ERR_LENGTH},
    '{scfp_pkg::SYNC_WORD[0], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[1], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[2], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[3], ROW_QUIET,    8'h00},
    '{scfp_pkg::CMD_SAVE,     ROW_QUIET,    8'h00},
    '{8'h00,                  ROW_QUIET,    8'h00},
    '{scfp_pkg::CMD_SAVE,     ROW_PREDICT,  8'h00},
    '{scfp_pkg::SYNC_WORD[0], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[1], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[2], ROW_QUIET,    8'h00},
    '{scfp_pkg::SYNC_WORD[3], ROW_QUIET,    8'h00},
    '{scfp_pkg::CMD_RESTORE,  ROW_QUIET,    8'h00},
    '{8'h00,                  ROW_QUIET,    8'h00},
    '{8'hFF,                  ROW_ERROR,    scfp_pkg::ERR_SUM}
  };

  serial_command_frame_parser_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // frame builders, all append to reply_frame
  function automatic void queue_tx_byte(logic [7:0] d, logic last, logic save);
    tx_beat_t b;
    b.data = d;
    b.last = last;
    b.save = save;
    reply_frame.push_back(b);
  endfunction

  function automatic void build_error(logic [7:0] code);
    for (int i = 0; i < 4; i++) queue_tx_byte(scfp_pkg::SYNC_WORD[i], 1'b0, 1'b0);
    queue_tx_byte(scfp_pkg::ERR_HDR, 1'b0, 1'b0);
    queue_tx_byte(8'(scfp_pkg::ERR_LEN), 1'b0, 1'b0);
    queue_tx_byte(code, 1'b0, 1'b0);
    queue_tx_byte(8'(scfp_pkg::ERR_HDR + 8'(scfp_pkg::ERR_LEN) + code), 1'b1, 1'b0);
  endfunction

  function automatic void build_response(logic [7:0] cmd, int n, logic save);
    logic [7:0] head;
    logic [7:0] sum;
    head = cmd | scfp_pkg::RESP_FLAG;
    sum = head + 8'(n);
    for (int i = 0; i < 4; i++) queue_tx_byte(scfp_pkg::SYNC_WORD[i], 1'b0, 1'b0);
    queue_tx_byte(head, 1'b0, 1'b0);
    queue_tx_byte(8'(n), 1'b0, 1'b0);
    for (int i = 0; i < n; i++) begin
      sum = sum + reply_body[i];
      queue_tx_byte(reply_body[i], 1'b0, 1'b0);
    end
    queue_tx_byte(sum, 1'b1, save);
  endfunction

  // get reply: the settings padded with zeros
  function automatic void build_settings_reply(logic [7:0] src [scfp_pkg::SETTINGS_LEN]);
    foreach (reply_body[i]) reply_body[i] = 8'h00;
    for (int i = 0; i < scfp_pkg::SETTINGS_LEN; i++) reply_body[i] = src[i];
    build_response(scfp_pkg::CMD_GET, int'(scfp_pkg::GET_LEN), 1'b0);
  endfunction

  // checksum byte received: run the command
  function automatic void finish_frame(logic [7:0] b);
    logic [7:0] sum;
    sum = rx_cmd + rx_len;
    for (int i = 0; i < rx_len; i++) sum = sum + rx_payload[i];
    if (sum != b) begin
      build_error(scfp_pkg::ERR_SUM);
    end else if (rx_cmd == scfp_pkg::CMD_GET && rx_len == 8'h00) begin
      build_settings_reply(stored_settings);
    end else if (rx_cmd == scfp_pkg::CMD_SET && rx_len == scfp_pkg::SET_LEN) begin
      if (rx_payload[0] != scfp_pkg::SET_VER) begin
        build_error(scfp_pkg::ERR_VERSION);
      end else begin
        for (int i = 0; i < scfp_pkg::SETTINGS_LEN; i++) stored_settings[i] = rx_payload[i];
        build_response(scfp_pkg::CMD_SET, 0, 1'b0);
      end
    end else if (rx_cmd == scfp_pkg::CMD_SAVE && rx_len == 8'h00) begin
      build_response(scfp_pkg::CMD_SAVE, 0, 1'b1);
    end else if (rx_cmd == scfp_pkg::CMD_RESTORE && rx_len == 8'h00) begin
      stored_settings = scfp_pkg::FACTORY;
      build_response(scfp_pkg::CMD_RESTORE, 0, 1'b0);
    end else begin
      build_error(scfp_pkg::ERR_COMMAND);
    end
  endfunction

  // one received byte through the parser
  function automatic void predict_rx_byte(logic [7:0] b);
    case (rx_phase)
      scfp_pkg::PH_SYNC0, scfp_pkg::PH_SYNC1, scfp_pkg::PH_SYNC2,
      scfp_pkg::PH_SYNC3: begin
        if (b == scfp_pkg::SYNC_WORD[rx_phase[1:0]])
          rx_phase = scfp_pkg::phase_t'(rx_phase + 1);
        else rx_phase = scfp_pkg::PH_SYNC0;
      end
      scfp_pkg::PH_CMD: begin
        rx_cmd = b;
        rx_phase = scfp_pkg::PH_LEN;
      end
      scfp_pkg::PH_LEN: begin
        rx_len = b;
        rx_idx = 0;
        if (b > scfp_pkg::PAYLOAD_CAPACITY) begin
          rx_phase = scfp_pkg::PH_SYNC0;
          build_error(scfp_pkg::ERR_LENGTH);
        end else begin
          rx_phase = (b != 8'h00) ? scfp_pkg::PH_PAY : scfp_pkg::PH_CHK;
        end
      end
      scfp_pkg::PH_PAY: begin
        if (rx_idx < scfp_pkg::PAYLOAD_CAPACITY) rx_payload[rx_idx] = b;
        rx_idx++;
        if (rx_idx >= rx_len) rx_phase = scfp_pkg::PH_CHK;
      end
      default: begin
        finish_frame(b);
        rx_phase = scfp_pkg::PH_SYNC0;
      end
    endcase
  endfunction

  function automatic void flag_mismatch(tx_beat_t want, logic [7:0] d, logic l, logic s,
                                        bit orphan);
    if (mismatches < REPORT_LIMIT) begin
      if (orphan)
        $display("unexpected out beat: data %h last %b save %b", d, l, s);
      else
        $display("out beat mismatch: expected data %h last %b save %b, got %h %b %b",
                 want.data, want.last, want.save, d, l, s);
    end
    mismatches++;
  endfunction

  function automatic void check_tx_beat(logic [7:0] d, logic l, logic s);
    tx_beat_t want;
    tx_count++;
    want = '0;
    if (tx_expected.size() == 0) begin
      flag_mismatch(want, d, l, s, 1'b1);
    end else begin
      want = tx_expected.pop_front();
      if (want.data != d || want.last != l || want.save != s)
        flag_mismatch(want, d, l, s, 1'b0);
    end
  endfunction

  // monitor: predict on every accepted input beat, check every output beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      reply_frame = {};
      predict_rx_byte(in_tdata);
      if (beat_kind != ROW_PREDICT) begin
        reply_frame = {};
        case (beat_kind)
          ROW_ERROR:    build_error(beat_code);
          ROW_DEFAULTS: build_settings_reply(scfp_pkg::FACTORY);
          default:      ;
        endcase
      end
      foreach (reply_frame[i]) tx_expected.push_back(reply_frame[i]);
    end
    if (rst_n && out_tvalid && out_tready) check_tx_beat(out_tdata, out_tlast, out_tuser);
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(logic [7:0] b, row_kind_t kind, logic [7:0] code);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    beat_kind <= kind;
    beat_code <= code;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_in(int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // one random frame: mostly well formed, some noise, bad sums and oversize lengths
  task automatic send_random_frame();
    int pick;
    int n;
    bit noise;
    bit calm;
    bit corrupt;
    bit force_ver;
    logic [7:0] ver_byte;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] pay;
    logic [7:0] body [$];
    pick = $urandom_range(0, 99);
    noise = (pick < 10);
    calm = ($urandom_range(0, 3) == 0);
    corrupt = 1'b0;
    force_ver = 1'b0;
    ver_byte = scfp_pkg::SET_VER;
    cmd = scfp_pkg::CMD_GET;
    len = 8'h00;
    if (noise) begin
      // partial sync word then junk
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) body.push_back(scfp_pkg::SYNC_WORD[i]);
      n = $urandom_range(1, 5);
      repeat (n) body.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < 4; i++) body.push_back(scfp_pkg::SYNC_WORD[i]);
      if (pick < 16) begin
        // oversize length, the rest of the frame falls back into the hunt
        body.push_back(8'($urandom));
        body.push_back(8'($urandom_range(scfp_pkg::PAYLOAD_CAPACITY + 1, 255)));
        n = $urandom_range(0, 4);
        repeat (n) body.push_back(8'($urandom));
      end else begin
        if (pick < 30) begin
          cmd = scfp_pkg::CMD_GET;
        end else if (pick < 52) begin
          cmd = scfp_pkg::CMD_SET;
          len = scfp_pkg::SET_LEN;
          force_ver = 1'b1;
        end else if (pick < 60) begin
          // set with a wrong version byte
          cmd = scfp_pkg::CMD_SET;
          len = scfp_pkg::SET_LEN;
          force_ver = 1'b1;
          ver_byte = scfp_pkg::SET_VER ^ 8'($urandom_range(1, 255));
        end else if (pick < 68) begin
          cmd = scfp_pkg::CMD_SAVE;
        end else if (pick < 76) begin
          cmd = scfp_pkg::CMD_RESTORE;
        end else if (pick < 88) begin
          cmd = 8'($urandom);
          if ($urandom_range(0, 5) == 0) len = 8'(scfp_pkg::PAYLOAD_CAPACITY);
          else len = 8'($urandom_range(0, scfp_pkg::PAYLOAD_CAPACITY));
        end else begin
          cmd = scfp_pkg::CMD_GET + 8'($urandom_range(0, 3));
          len = (cmd == scfp_pkg::CMD_SET) ? scfp_pkg::SET_LEN : 8'h00;
          corrupt = 1'b1;
        end
        body.push_back(cmd);
        body.push_back(len);
        sum = cmd + len;
        for (int i = 0; i < len; i++) begin
          pay = (i == 0 && force_ver) ? ver_byte : 8'($urandom);
          sum = sum + pay;
          body.push_back(pay);
        end
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        body.push_back(sum);
      end
    end
    foreach (body[i]) begin
      send_beat(body[i], ROW_PREDICT, 8'h00);
      idle_in(calm ? 0 : pick_gap());
    end
    rx_items += body.size();
  endtask

  // receiver: random stalls, calm stretches, one long hold-off
  initial begin
    int stall_left;
    int calm_left;
    bit held;
    stall_left = 0;
    calm_left = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && tx_count >= 100) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
        else stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  // stimulus
  initial begin
    int frames;
    rx_phase = scfp_pkg::PH_SYNC0;
    rx_cmd = 8'h00;
    rx_len = 8'h00;
    rx_idx = 0;
    foreach (rx_payload[i]) rx_payload[i] = 8'h00;
    stored_settings = scfp_pkg::FACTORY;
    frames = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].rx, directed_rows[r].kind, directed_rows[r].code);
      idle_in(pick_gap());
    end
    rx_items = $size(directed_rows);

    while (rx_items < RX_ITEMS) begin
      send_random_frame();
      frames++;
      // sender holds back until every reply has drained
      if (frames == 12) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (tx_expected.size() != 0) @(posedge clk);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tx_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
